FILE: rtl/hte_pkg.sv
`default_nettype none
package hte_pkg;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;

  // Accumulator: up to seven pending bits ahead of one full-width code
  localparam int unsigned PEND_W = BYTE_W - 1;
  localparam int unsigned CNT_W  = $clog2(BYTE_W);
  localparam int unsigned ACC_W  = PEND_W + CODE_W;
  localparam int unsigned TOT_W  = $clog2(ACC_W + 1);

  // Parameter defaults
  localparam int unsigned DEF_MAX_CODE_LEN = 32;
  localparam int unsigned DEF_SYMBOL_COUNT = 256;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } hte_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT,
    ST_FLUSH
  } hte_state_e;

  typedef struct packed {
    hte_op_e            opcode;
    logic [SYM_W-1:0]   symbol;
    logic [CODE_W-1:0]  code_value;
    logic [LEN_W-1:0]   code_length;
  } hte_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } hte_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;
    logic rd_en;
    logic merge;
    logic emit;
    logic finish;
    logic flush_emit;
  } hte_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sym_ok;
    logic has_byte;
    logic pend_nz;
    logic can_emit;
  } hte_status_t;

endpackage
`default_nettype wire

FILE: rtl/hte_dp.sv
`default_nettype none
module hte_dp import hte_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int unsigned SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire hte_in_t     in_data_i,
  input  wire hte_cmd_t    cmd_i,
  output      hte_status_t status_o,
  input  wire logic        out_ready_i,
  output      logic        out_valid_o,
  output      hte_out_t    out_data_o
);

  localparam int unsigned IDX_W     = $clog2(SYMBOL_COUNT);
  localparam int unsigned LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_LIMIT);

  // Table word: saturated length above code bits
  logic [LEN_W+CODE_W-1:0] mem [SYMBOL_COUNT];
  logic [LEN_W+CODE_W-1:0] rd_q;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]  pcount_q, pcount_d;
  hte_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  rd_len;
  logic [CODE_W-1:0] rd_code;
  logic [CODE_W:0]   code_mask;
  logic [TOT_W-1:0]  emit_sh;
  logic [ACC_W-1:0]  emit_word;
  logic [PEND_W:0]   fin_mask;
  logic [CNT_W:0]    flush_sh;
  logic [BYTE_W-1:0] flush_byte;

  assign idx     = in_data_i.symbol[IDX_W-1:0];
  assign len_sat = (in_data_i.code_length > LEN_MAX) ? LEN_MAX : in_data_i.code_length;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem[idx] <= {len_sat, in_data_i.code_value};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx];
    end
  end

  assign rd_len    = rd_q[LEN_W+CODE_W-1:CODE_W];
  assign rd_code   = rd_q[CODE_W-1:0];
  assign code_mask = ((CODE_W + 1)'(1) << rd_len) - (CODE_W + 1)'(1);

  assign emit_sh    = total_q - TOT_W'(BYTE_W);
  assign emit_word  = acc_q >> emit_sh;
  assign fin_mask   = ((PEND_W + 1)'(1) << total_q[CNT_W-1:0]) - (PEND_W + 1)'(1);
  assign flush_sh   = (CNT_W + 1)'(BYTE_W) - {1'b0, pcount_q};
  assign flush_byte = {1'b0, pend_q} << flush_sh;

  always_comb begin
    acc_d       = acc_q;
    total_d     = total_q;
    pend_d      = pend_q;
    pcount_d    = pcount_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.merge) begin
      acc_d   = ({{CODE_W{1'b0}}, pend_q} << rd_len)
              | {{PEND_W{1'b0}}, rd_code & code_mask[CODE_W-1:0]};
      total_d = TOT_W'(pcount_q) + TOT_W'(rd_len);
    end
    if (cmd_i.emit) begin
      total_d           = emit_sh;
      out_d.out_byte    = emit_word[BYTE_W-1:0];
      out_d.last_of_run = (total_q < TOT_W'(2 * BYTE_W));
      out_valid_d       = 1'b1;
    end
    if (cmd_i.finish) begin
      pend_d   = acc_q[PEND_W-1:0] & fin_mask[PEND_W-1:0];
      pcount_d = total_q[CNT_W-1:0];
    end
    if (cmd_i.flush_emit) begin
      out_d.out_byte    = flush_byte;
      out_d.last_of_run = 1'b1;
      out_valid_d       = 1'b1;
      pend_d            = '0;
      pcount_d          = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      pcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      pcount_q    <= pcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    total_q <= total_d;
    out_q   <= out_d;
  end

  assign status_o.sym_ok   = ({1'b0, in_data_i.symbol} < SYM_LIMIT);
  assign status_o.has_byte = (total_q >= TOT_W'(BYTE_W));
  assign status_o.pend_nz  = (pcount_q != '0);
  assign status_o.can_emit = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: rtl/hte_ctrl.sv
`default_nettype none
module hte_ctrl import hte_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire hte_op_e     opcode_i,
  output      logic        in_ready_o,
  input  wire hte_status_t status_i,
  output      hte_cmd_t    cmd_o
);

  hte_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == OP_ENCODE && status_i.sym_ok) begin
          state_d = ST_LOOKUP;
        end else if (accept && opcode_i == OP_FLUSH && status_i.pend_nz) begin
          state_d = ST_FLUSH;
        end
      end
      ST_LOOKUP: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!status_i.has_byte) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status_i.can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_we    = accept && opcode_i == OP_LOAD && status_i.sym_ok;
    cmd_o.rd_en      = accept && opcode_i == OP_ENCODE && status_i.sym_ok;
    cmd_o.merge      = (state_q == ST_LOOKUP);
    cmd_o.emit       = (state_q == ST_EMIT) && status_i.has_byte && status_i.can_emit;
    cmd_o.finish     = (state_q == ST_EMIT) && !status_i.has_byte;
    cmd_o.flush_emit = (state_q == ST_FLUSH) && status_i.can_emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/huffman_table_encoder_packer.sv
// Huffman encoder with a loaded code table and an MSB-first byte packer.
// Each input transfer carries an opcode: load writes the code and length for
// one symbol (lengths above the code limit saturate), encode appends that
// symbol's code to the bit accumulator and emits every completed byte, flush
// emits the pending partial byte padded with zero low bits and clears the
// accumulator. Each output transfer is one byte, earliest bit in bit 7, with
// last_of_run set on the final byte of the causing input transfer. The block
// handles one input transfer at a time. A load, an empty flush, an ignored
// opcode or an out-of-range symbol leaves the block idle; a flush with
// pending bits passes through the flush state; an encode emits 0 to 4 bytes,
// passing through the registered table read, the merge into the accumulator,
// and the output register, one byte per cycle while downstream is ready.
// Output backpressure stretches the emit phase. The output register lets the
// next input transfer be taken while the last byte still waits downstream.
// Encoding a symbol whose table entry was never loaded yields undefined bytes.
`default_nettype none
module huffman_table_encoder_packer import hte_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int unsigned SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire hte_in_t  in_data_i,
  output      logic     out_valid_o,
  input  wire logic     out_ready_i,
  output      hte_out_t out_data_o
);

  // Command and status between sequencer and datapath
  hte_cmd_t    cmd;
  hte_status_t status;

  // Sequence load, lookup, merge, emit and flush phases
  hte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_data_i.opcode),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the code table, accumulator and output register
  hte_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: rtl/hte_checker.sv
`default_nettype none
module hte_checker import hte_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire hte_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire hte_out_t out_data_o
);

  // Stalled output transfer holds its byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output byte changed while stalled");

  // A load finishes in its own cycle
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.opcode == OP_LOAD |=> in_ready_o)
    else $error("input not ready after a load");

  // Bytes of one run follow without a gap
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("gap inside a run of output bytes");

  // No new input while a run is unfinished
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> !in_ready_o)
    else $error("input ready in the middle of a run");

endmodule

bind huffman_table_encoder_packer hte_checker u_hte_checker (.*);
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import hte_pkg::*;

  // Effective code length cap: the parameter, but never wider than code_value
  localparam int unsigned CODE_LIMIT =
    (DEF_MAX_CODE_LEN < CODE_W) ? DEF_MAX_CODE_LEN : CODE_W;
  // Opcode 3 has no meaning; the block must swallow it silently
  localparam hte_op_e OP_UNUSED = hte_op_e'(2'd3);
  localparam int unsigned RAND_PER_PHASE = 32;
  // Longest encode emits four bytes; settle well beyond it
  localparam int unsigned SETTLE_CYCLES = 20;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  hte_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  hte_out_t out_data_o;

  huffman_table_encoder_packer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Items waiting to be driven, and bytes the block still owes us
  hte_in_t  tx_items[$];
  hte_out_t owed_bytes[$];

  // Shadow of the block: code table and the bit accumulator
  logic [CODE_W-1:0] code_mem[DEF_SYMBOL_COUNT];
  int unsigned       len_mem[DEF_SYMBOL_COUNT];
  logic [PEND_W-1:0] acc_bits = '0;
  int unsigned       acc_cnt  = 0;

  // Generator bookkeeping: encode only symbols whose entry was loaded
  bit          sym_loaded[DEF_SYMBOL_COUNT];
  int unsigned loaded_syms[$];

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  logic        in_took   = 1'b0;
  int unsigned err_count = 0;

  // Apply one accepted item to the shadow state and queue the bytes it owes.
  function automatic void pack_item(input hte_in_t item);
    int unsigned len;
    int unsigned total;
    logic [63:0] acc;
    logic [BYTE_W-1:0] tail;
    hte_out_t res;
    case (item.opcode)
      OP_LOAD: begin
        if (item.symbol < DEF_SYMBOL_COUNT) begin
          // Saturate overlong codes at load time
          len = (item.code_length > CODE_LIMIT) ? CODE_LIMIT : item.code_length;
          code_mem[item.symbol] = item.code_value;
          len_mem[item.symbol]  = len;
        end
      end
      OP_ENCODE: begin
        if (item.symbol < DEF_SYMBOL_COUNT) begin
          len = len_mem[item.symbol];
          // Append the code below the pending bits, then peel off whole bytes
          acc = ({{(64-PEND_W){1'b0}}, acc_bits} << len)
              | ({32'd0, code_mem[item.symbol]} & ((64'd1 << len) - 64'd1));
          total = acc_cnt + len;
          while (total >= BYTE_W) begin
            total -= BYTE_W;
            res.out_byte    = acc[total +: BYTE_W];
            res.last_of_run = (total < BYTE_W);
            owed_bytes.push_back(res);
          end
          acc_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
          acc_cnt  = total;
        end
      end
      OP_FLUSH: begin
        // Pad the partial byte with zero low bits; an empty flush owes nothing
        if (acc_cnt != 0) begin
          tail            = {1'b0, acc_bits};
          res.out_byte    = tail << (BYTE_W - acc_cnt);
          res.last_of_run = 1'b1;
          owed_bytes.push_back(res);
        end
        acc_bits = '0;
        acc_cnt  = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic queue_item(input hte_op_e op, input int unsigned sym,
                            input logic [CODE_W-1:0] code, input int unsigned len);
    hte_in_t item;
    item.opcode      = op;
    item.symbol      = SYM_W'(sym);
    item.code_value  = code;
    item.code_length = LEN_W'(len);
    tx_items.push_back(item);
    if (op == OP_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Mostly loads and encodes of loaded symbols, some flushes, a little noise.
  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    int unsigned len;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 25 || loaded_syms.size() == 0) begin
        // Keep codes short most of the time, with the odd overlong or empty one
        len = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(12, 1);
        queue_item(OP_LOAD, $urandom_range(255), $urandom, len);
      end else if (pick < 85) begin
        queue_item(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                   $urandom, $urandom_range(63));
      end else if (pick < 96) begin
        queue_item(OP_FLUSH, $urandom_range(255), $urandom, $urandom_range(63));
      end else begin
        queue_item(OP_UNUSED, $urandom_range(255), $urandom, $urandom_range(63));
      end
    end
  endtask

  // Hold until every item is driven and every owed byte has come back.
  task automatic wait_drained();
    while (tx_items.size() != 0 || in_valid_i || owed_bytes.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: change inputs on the falling edge only. Hold the current item
  // until its transfer, then either present the next one or idle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (tx_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_data_i  <= tx_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: sample both channels on the rising edge. Predict on the input
  // transfer first so its bytes queue behind those of earlier items.
  always @(posedge clk_i) begin
    hte_out_t want;
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        pack_item(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (owed_bytes.size() == 0) begin
          $display("%0t: unexpected output, got byte %h last %b",
                   $time, out_data_o.out_byte, out_data_o.last_of_run);
          err_count++;
        end else begin
          want = owed_bytes.pop_front();
          if (out_data_o.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h got %h",
                     $time, want.out_byte, out_data_o.out_byte);
            err_count++;
          end
          if (out_data_o.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b got %b",
                     $time, want.last_of_run, out_data_o.last_of_run);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    // Hold reset, then release it on a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase one: sender rarely idles, receiver stalls about half the time
    send_idle = 8;
    recv_idle = 51;

    // Directed: table extremes, saturation, zero length, byte boundaries
    queue_item(OP_LOAD, 0, 32'h0000_0001, 1);
    queue_item(OP_LOAD, 255, 32'hFFFF_FFFF, 32);
    queue_item(OP_LOAD, 1, 32'hFFFF_FFFF, 0);     // zero-length code
    queue_item(OP_LOAD, 2, 32'hA5A5_A5A5, 63);    // overlong, saturates
    queue_item(OP_LOAD, 3, 32'h0000_0000, 7);
    queue_item(OP_LOAD, 4, 32'h0000_005A, 8);
    queue_item(OP_ENCODE, 0, '0, 0);              // one bit pending
    queue_item(OP_ENCODE, 255, '0, 0);            // 33 bits: four bytes out
    queue_item(OP_ENCODE, 3, '0, 0);              // lands exactly on a byte
    queue_item(OP_ENCODE, 4, '0, 0);              // one whole byte
    queue_item(OP_ENCODE, 1, '0, 0);              // emits nothing
    queue_item(OP_FLUSH, 0, '0, 0);               // nothing pending
    queue_item(OP_ENCODE, 3, '0, 0);              // seven bits pending
    queue_item(OP_ENCODE, 2, '0, 0);              // 39 bits: four bytes out
    queue_item(OP_FLUSH, 255, 32'hFFFF_FFFF, 63); // partial byte out
    queue_item(OP_UNUSED, 255, 32'hFFFF_FFFF, 63);
    queue_item(OP_LOAD, 8'h55, 32'h2AAA_AAAA, 33);
    queue_item(OP_ENCODE, 8'h55, '0, 0);
    queue_item(OP_FLUSH, 0, '0, 0);
    queue_item(OP_LOAD, 8'hAA, 32'h0000_0003, 2);
    queue_item(OP_ENCODE, 8'hAA, '0, 0);
    queue_item(OP_FLUSH, 0, '0, 0);
    queue_random(RAND_PER_PHASE);
    wait_drained();

    // Phase two: swap the idling roles
    send_idle = 51;
    recv_idle = 8;
    queue_random(RAND_PER_PHASE);
    wait_drained();

    // Phase three: full throughput, no idling on either side
    send_idle = 0;
    recv_idle = 0;
    queue_random(RAND_PER_PHASE);
    queue_item(OP_FLUSH, 0, '0, 0);
    wait_drained();

    // Let any stray output show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (owed_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived, next expected %h",
               $time, owed_bytes.size(), owed_bytes[0].out_byte);
      err_count++;
    end
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
